### rtl/core/fpbp_pkg.sv
`timescale 1ns / 1ps

package fpbp_pkg;

   // Image geometry
   localparam int IMAGE_SIZE = 256;
   localparam int IMG_BITS   = $clog2(IMAGE_SIZE);
   localparam int PIX_BITS   = 2 * IMG_BITS;
   localparam int N1         = IMAGE_SIZE - 1;

   // Fixed point layout of the detector position
   localparam int FRAC_BITS   = 9;
   localparam int SUB_BITS    = 9;
   localparam int SAMPLE_BITS = 10;
   localparam int POS_SHIFT   = FRAC_BITS + SUB_BITS;

   // Field widths
   localparam int CMD_W      = 2;
   localparam int COORD_W    = 8;
   localparam int SAMPLE_W   = SAMPLE_BITS + 2;
   localparam int TRIG_W     = 20;
   localparam int ACC_W      = 32;
   localparam int RADIUS_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int BIN_W      = ACC_W - POS_SHIFT;

   typedef logic [CMD_W-1:0]             cmd_type;
   typedef logic [COORD_W-1:0]           coord_type;
   typedef logic signed [SAMPLE_W-1:0]   sample_type;
   typedef logic signed [TRIG_W-1:0]     trig_type;
   typedef logic signed [ACC_W-1:0]      acc_type;
   typedef logic [RADIUS_W-1:0]          radius_type;
   typedef logic [CSR_IDX_W-1:0]         csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]        csr_data_type;

   // Command codes
   localparam cmd_type CMD_CLEAR = 2'd0;
   localparam cmd_type CMD_LOAD  = 2'd1;
   localparam cmd_type CMD_BPROJ = 2'd2;
   localparam cmd_type CMD_READ  = 2'd3;

   // Register indexes
   localparam csr_idx_type CSR_VIEW_OFFSET = 2'd0;
   localparam csr_idx_type CSR_RADIUS      = 2'd1;

   // Register reset values
   localparam acc_type    VIEW_OFFSET_RESET = -32'sd33685504;
   localparam radius_type RADIUS_RESET      = 16'd65025;

endpackage

### rtl/core/fixed_point_backprojector_top.sv
// Throughput: one command at a time; backproject walks one pixel per cycle through
//   the accumulator memory's single read and single write port.
// Reset: synchronous, active high; afterwards a clearing pass zeroes the accumulator
//   memory with req_ready low; csr writes still taken.
`timescale 1ns / 1ps

module fixed_point_backprojector_top (
   input  logic                    clock,
   input  logic                    reset,
   // command channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  fpbp_pkg::cmd_type       req_command,
   input  fpbp_pkg::coord_type     req_sample_index,
   input  fpbp_pkg::sample_type    req_sample_value,
   input  fpbp_pkg::trig_type      req_sine_value,
   input  fpbp_pkg::trig_type      req_cosine_value,
   input  fpbp_pkg::coord_type     req_pixel_row,
   input  fpbp_pkg::coord_type     req_pixel_col,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output fpbp_pkg::acc_type       rsp_pixel_value,
   output logic                    rsp_done_res,
   // register write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  fpbp_pkg::csr_idx_type   csr_index,
   input  fpbp_pkg::csr_data_type  csr_data
);
   import fpbp_pkg::*;

   localparam int DV_W   = IMG_BITS + 2;
   localparam int SQ_W   = 2 * DV_W;
   localparam int DQ_W   = SAMPLE_W + 1;
   localparam int PROD_W = TRIG_W + 1 + IMG_BITS + 1;

   localparam logic [IMG_BITS-1:0] IMG_LAST = IMG_BITS'(IMAGE_SIZE - 1);
   localparam logic [PIX_BITS-1:0] PIX_LAST = '1;

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CLEAR = 3'd2;
   localparam logic [2:0] ST_SETUP = 3'd3;
   localparam logic [2:0] ST_RUN   = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;
   localparam logic [2:0] ST_READ  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   // ------------------------------------------------------------------
   // Storage: line store (one entry per detector bin; the two end
   // sentinels are not stored, they come from the range checks) and the
   // image accumulator.
   // ------------------------------------------------------------------
   sample_type line_mem [IMAGE_SIZE];
   acc_type    acc_mem  [IMAGE_SIZE * IMAGE_SIZE];

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic [2:0]            state_ff, state_in;
   logic [PIX_BITS-1:0]   sweep_ff, sweep_in;
   logic [IMG_BITS-1:0]   row_ff, row_in;
   logic [IMG_BITS-1:0]   col_ff, col_in;
   acc_type               rh_ff, rh_in;
   acc_type               row_rh_ff, row_rh_in;
   acc_type               pend_value_ff, pend_value_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   acc_type               rsp_value_ff, rsp_value_in;
   trig_type              sine_ff, cosine_ff;
   logic                  rd_ok_ff;
   acc_type               view_offset_ff;
   radius_type            radius_ff;
   logic [IMAGE_SIZE-1:0] line_vld_ff;

   // pixel pipeline: stage B holds line data, stage C holds accumulator data
   logic                  b_vld_ff, c_vld_ff;
   logic [PIX_BITS-1:0]   b_addr_ff, c_addr_ff;
   logic [FRAC_BITS-1:0]  b_frac_ff;
   logic                  b_disk_ff, c_disk_ff;
   logic                  b_ok0_ff, b_ok1_ff;
   sample_type            line_q0_ff, line_q1_ff;
   acc_type               c_add_ff;
   acc_type               acc_rd_ff;

   // ------------------------------------------------------------------
   // Handshake decode
   // ------------------------------------------------------------------
   logic req_fire;
   logic load_we;
   logic read_hit;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign load_we   = req_fire && (req_command == CMD_LOAD) &&
                      (32'(req_sample_index) < IMAGE_SIZE);
   assign read_hit  = (32'(req_pixel_row) < IMAGE_SIZE) &&
                      (32'(req_pixel_col) < IMAGE_SIZE);

   assign csr_ready = 1'b1;

   // ------------------------------------------------------------------
   // View setup: base = trunc((N1*(s-c)+1)/2) - view_offset, wrapped to 32 bits
   // ------------------------------------------------------------------
   logic signed [TRIG_W:0]   trig_diff;
   logic signed [PROD_W-1:0] setup_prod;
   logic signed [PROD_W-1:0] setup_half;
   acc_type                  setup_base;
   acc_type                  sine_ext;
   acc_type                  cosine_ext;

   always_comb begin
      trig_diff  = (TRIG_W + 1)'(sine_ff) - (TRIG_W + 1)'(cosine_ff);
      setup_prod = PROD_W'(trig_diff) * PROD_W'(N1) + PROD_W'(1);
      // round the halving toward zero: bump negative odd values by one
      setup_half = (setup_prod >>> 1) +
                   $signed(PROD_W'(setup_prod[PROD_W-1] & setup_prod[0]));
      setup_base = ACC_W'(setup_half) - view_offset_ff;
      sine_ext   = ACC_W'(sine_ff);
      cosine_ext = ACC_W'(cosine_ff);
   end

   // ------------------------------------------------------------------
   // Stage A: current pixel -> detector bin, fraction, disk test
   // ------------------------------------------------------------------
   logic                     a_vld;
   logic signed [BIN_W-1:0]  a_bin;
   logic                     a_ok0, a_ok1;
   logic [IMG_BITS-1:0]      a_adr0, a_adr1;
   logic signed [DV_W-1:0]   a_dv, a_dh;
   logic signed [SQ_W-1:0]   a_dv_sq, a_dh_sq;
   logic [SQ_W:0]            a_dist;
   logic                     a_disk;

   always_comb begin
      a_vld  = (state_ff == ST_RUN);
      a_bin  = rh_ff[ACC_W-1:POS_SHIFT];
      // line entry n holds bin n-1; entry 0 and the last entry read as zero
      a_ok0  = (a_bin >= 1) && (a_bin <= IMAGE_SIZE);
      a_ok1  = (a_bin >= 0) && (a_bin < IMAGE_SIZE);
      a_adr0 = IMG_BITS'(a_bin - BIN_W'(1));
      a_adr1 = a_bin[IMG_BITS-1:0];
      a_dv    = DV_W'($signed({1'b0, row_ff, 1'b0}) - N1);
      a_dh    = DV_W'($signed({1'b0, col_ff, 1'b0}) - N1);
      a_dv_sq = a_dv * a_dv;
      a_dh_sq = a_dh * a_dh;
      a_dist  = (SQ_W + 1)'($unsigned(a_dv_sq)) + (SQ_W + 1)'($unsigned(a_dh_sq));
      a_disk  = (a_dist <= (SQ_W + 1)'(radius_ff));
   end

   // ------------------------------------------------------------------
   // Stage B: interpolate q0*2^FRAC_BITS + (q1-q0)*frac
   // ------------------------------------------------------------------
   sample_type                       b_q0, b_q1;
   logic signed [DQ_W-1:0]           b_dq;
   logic signed [DQ_W+FRAC_BITS:0]   b_slope;
   acc_type                          b_add;

   always_comb begin
      b_q0    = b_ok0_ff ? line_q0_ff : '0;
      b_q1    = b_ok1_ff ? line_q1_ff : '0;
      b_dq    = DQ_W'(b_q1) - DQ_W'(b_q0);
      b_slope = b_dq * $signed({1'b0, b_frac_ff});
      b_add   = (ACC_W'(b_q0) <<< FRAC_BITS) + ACC_W'(b_slope);
   end

   // ------------------------------------------------------------------
   // Accumulator ports. Pixels of one view are all distinct and commands
   // never overlap, so the read-modify-write needs no forwarding.
   // ------------------------------------------------------------------
   logic                acc_re, acc_we, sweeping;
   logic [PIX_BITS-1:0] acc_ra, acc_wa;
   acc_type             acc_wd;

   always_comb begin
      sweeping = (state_ff == ST_INIT) || (state_ff == ST_CLEAR);
      acc_re   = b_vld_ff || (req_fire && (req_command == CMD_READ));
      acc_ra   = b_vld_ff ? b_addr_ff :
                 {req_pixel_row[IMG_BITS-1:0], req_pixel_col[IMG_BITS-1:0]};
      acc_we   = sweeping || (c_vld_ff && c_disk_ff);
      acc_wa   = sweeping ? sweep_ff : c_addr_ff;
      acc_wd   = sweeping ? '0 : (acc_rd_ff + c_add_ff);
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_wa] <= acc_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_re) begin
         acc_rd_ff <= acc_mem[acc_ra];
      end
   end

   // line store: write on load, two reads per pixel
   always_ff @(posedge clock) begin
      if (load_we) begin
         line_mem[req_sample_index[IMG_BITS-1:0]] <= req_sample_value;
      end
   end

   always_ff @(posedge clock) begin
      if (a_vld) begin
         line_q0_ff <= line_mem[a_adr0];
         line_q1_ff <= line_mem[a_adr1];
      end
   end

   // an entry never loaded since reset reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         line_vld_ff <= '0;
      end else if (load_we) begin
         line_vld_ff[req_sample_index[IMG_BITS-1:0]] <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      rh_in         = rh_ff;
      row_rh_in     = row_rh_ff;
      pend_value_in = pend_value_ff;
      case (state_ff)
         ST_INIT: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == PIX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               pend_value_in = '0;
               case (req_command)
                  CMD_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_LOAD:  state_in = ST_DONE;
                  CMD_BPROJ: state_in = ST_SETUP;
                  CMD_READ:  state_in = ST_READ;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == PIX_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_SETUP: begin
            rh_in     = setup_base;
            row_rh_in = setup_base;
            row_in    = '0;
            col_in    = '0;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            // step along the row by +c, down one row by -s
            if (col_ff == IMG_LAST) begin
               col_in    = '0;
               row_in    = row_ff + 1'b1;
               row_rh_in = row_rh_ff - sine_ext;
               rh_in     = row_rh_ff - sine_ext;
               if (row_ff == IMG_LAST) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               col_in = col_ff + 1'b1;
               rh_in  = rh_ff + cosine_ext;
            end
         end
         ST_DRAIN: begin
            if (!b_vld_ff && !c_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            pend_value_in = rd_ok_ff ? acc_rd_ff : '0;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response word: load it when the slot is free or being emptied
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = pend_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         b_vld_ff     <= a_vld;
         c_vld_ff     <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      col_ff        <= col_in;
      rh_ff         <= rh_in;
      row_rh_ff     <= row_rh_in;
      pend_value_ff <= pend_value_in;
      rsp_value_ff  <= rsp_value_in;
      // stage B and C payload
      b_addr_ff     <= {row_ff, col_ff};
      b_frac_ff     <= rh_ff[POS_SHIFT-1:SUB_BITS];
      b_disk_ff     <= a_disk;
      b_ok0_ff      <= a_ok0 && line_vld_ff[a_adr0];
      b_ok1_ff      <= a_ok1 && line_vld_ff[a_adr1];
      c_addr_ff     <= b_addr_ff;
      c_disk_ff     <= b_disk_ff;
      c_add_ff      <= b_add;
      if (req_fire) begin
         sine_ff   <= req_sine_value;
         cosine_ff <= req_cosine_value;
         rd_ok_ff  <= read_hit;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         view_offset_ff <= VIEW_OFFSET_RESET;
         radius_ff      <= RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VIEW_OFFSET: view_offset_ff <= csr_data;
            CSR_RADIUS:      radius_ff      <= csr_data[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_value_ff;
   assign rsp_done_res    = 1'b1;

endmodule

### rtl/core/fpbp_checker.sv
`timescale 1ns / 1ps

module fpbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pixel_value,
   input logic        rsp_done_res
);

   // one command at a time: ready drops right after a word is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while another is in progress");

   // reset starts the clearing pass with nothing pending on either side
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block not quiet after reset");

   // a new response word appears together with the return to idle
   a_rsp_with_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready && rsp_done_res)
      else $error("response word without command completion");

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_value))
      else $error("stalled response word changed");

endmodule

bind fixed_point_backprojector_top fpbp_checker u_fpbp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pixel_value (rsp_pixel_value),
   .rsp_done_res    (rsp_done_res)
);
